// File: sv/f8cfr_pkg.sv
// shared types and constants of the fletcher8 command frame receiver
package f8cfr_pkg;

    typedef enum logic [1:0] {
        KIND_CONTROL  = 2'd0,
        KIND_SETTINGS = 2'd1,
        KIND_MAG_CAL  = 2'd2,
        KIND_ACC_CAL  = 2'd3
    } frame_kind_t;

    typedef enum logic [2:0] {
        REG_CONTROL_HEADER  = 3'd0,
        REG_SETTINGS_HEADER = 3'd1,
        REG_MAG_CAL_HEADER  = 3'd2,
        REG_ACC_CAL_HEADER  = 3'd3,
        REG_SETTINGS_LEN    = 3'd4
    } cfg_index_t;

    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] CTRL_PAYLOAD_LEN = 8'd5;
    localparam logic [7:0] MAG_PAYLOAD_LEN  = 8'd48;
    localparam logic [7:0] ACC_PAYLOAD_LEN  = 8'd8;
    localparam logic [7:0] MAX_SETTINGS_LEN = 8'd251;
    localparam logic [15:0] IDLE_THROTTLE   = 16'd200;

    localparam logic [7:0] RESET_CONTROL_HEADER  = 8'd1;
    localparam logic [7:0] RESET_SETTINGS_HEADER = 8'd2;
    localparam logic [7:0] RESET_MAG_CAL_HEADER  = 8'd3;
    localparam logic [7:0] RESET_ACC_CAL_HEADER  = 8'd4;
    localparam logic [7:0] RESET_SETTINGS_LEN    = 8'd64;

    typedef struct packed {
        frame_kind_t  frame_kind;
        logic         checksum_ok;
        logic [15:0]  range_value;
        logic [7:0]   arm_value;
        logic [15:0]  throttle_value;
        logic         arm_rise;
        logic         arm_fall;
    } result_t;

endpackage

// File: sv/f8cfr_byte_if.sv
// received byte channel
interface f8cfr_byte_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] data_byte;

    modport source (output valid, output frame_start, output data_byte, input ready);
    modport sink (input valid, input frame_start, input data_byte, output ready);
endinterface

// File: sv/f8cfr_result_if.sv
// frame result channel
interface f8cfr_result_if import f8cfr_pkg::*; ();
    logic         valid;
    logic         ready;
    frame_kind_t  frame_kind;
    logic         checksum_ok;
    logic [15:0]  range_value;
    logic [7:0]   arm_value;
    logic [15:0]  throttle_value;
    logic         arm_rise;
    logic         arm_fall;

    modport source (
        output valid, output frame_kind, output checksum_ok, output range_value,
        output arm_value, output throttle_value, output arm_rise, output arm_fall,
        input ready
    );
    modport sink (
        input valid, input frame_kind, input checksum_ok, input range_value,
        input arm_value, input throttle_value, input arm_rise, input arm_fall,
        output ready
    );
endinterface

// File: sv/fletcher8_command_frame_receiver.sv
// command frame receiver with 8-bit fletcher check
//
//  channel     dir  payload                                          handshake
//  byte_in     in   frame_start, data_byte                           valid/ready
//  result_out  out  frame_kind, checksum_ok, range_value, arm_value, valid/ready
//                   throttle_value, arm_rise, arm_fall
//  cfg         in   cfg_wr_en, cfg_index, cfg_data                   write only
//
// one byte is taken every cycle while the skid register is empty; the result
// is registered when the second check byte is taken.
// reset loads the default headers, clears sums and arm state and sets throttle to 200;
// no clearing pass.
// a stalled result sits in the output register and one more in a skid register;
// byte_in drops ready only while the skid register is full.
module fletcher8_command_frame_receiver
    import f8cfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    f8cfr_byte_if.sink             byte_in,
    f8cfr_result_if.source         result_out
);

    logic [7:0] ctrl_hdr_reg;
    logic [7:0] set_hdr_reg;
    logic [7:0] mag_hdr_reg;
    logic [7:0] acc_hdr_reg;
    logic [7:0] set_len_reg;

    logic [7:0]  pos_reg, pos_next;
    logic        in_frame_reg, in_frame_next;
    frame_kind_t kind_reg, kind_next;
    logic [7:0]  sum_lo_reg, sum_lo_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;
    logic [7:0]  chk1_reg, chk1_next;
    logic [7:0]  arm_reg, arm_next;
    logic [15:0] thr_reg, thr_next;

    logic [7:0] ctrl_bytes [5];
    logic       ctrl_we;
    logic [2:0] ctrl_idx;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic       accept;
    logic [7:0] payload_len;
    logic [7:0] sum_lo_add;
    logic       has_result;
    result_t    res_new;
    logic       ok;

    assign byte_in.ready = !skid_valid_reg;
    assign accept        = byte_in.valid && byte_in.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_hdr_reg <= RESET_CONTROL_HEADER;
            set_hdr_reg  <= RESET_SETTINGS_HEADER;
            mag_hdr_reg  <= RESET_MAG_CAL_HEADER;
            acc_hdr_reg  <= RESET_ACC_CAL_HEADER;
            set_len_reg  <= RESET_SETTINGS_LEN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CONTROL_HEADER:  ctrl_hdr_reg <= cfg_data;
                REG_SETTINGS_HEADER: set_hdr_reg  <= cfg_data;
                REG_MAG_CAL_HEADER:  mag_hdr_reg  <= cfg_data;
                REG_ACC_CAL_HEADER:  acc_hdr_reg  <= cfg_data;
                REG_SETTINGS_LEN:    set_len_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_CONTROL:  payload_len = CTRL_PAYLOAD_LEN;
            KIND_SETTINGS: payload_len = (set_len_reg > MAX_SETTINGS_LEN) ?
                                         MAX_SETTINGS_LEN : set_len_reg;
            KIND_MAG_CAL:  payload_len = MAG_PAYLOAD_LEN;
            default:       payload_len = ACC_PAYLOAD_LEN;
        endcase
    end

    assign sum_lo_add = sum_lo_reg + byte_in.data_byte;

    // frame tracking, sums and control frame decode
    always_comb
    begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        kind_next     = kind_reg;
        sum_lo_next   = sum_lo_reg;
        sum_hi_next   = sum_hi_reg;
        chk1_next     = chk1_reg;
        arm_next      = arm_reg;
        thr_next      = thr_reg;
        ctrl_we       = 1'b0;
        ctrl_idx      = pos_reg[2:0] - 3'd1;
        has_result    = 1'b0;
        ok            = (chk1_reg == sum_lo_reg) && (byte_in.data_byte == sum_hi_reg);

        res_new                = '0;
        res_new.frame_kind     = kind_reg;
        res_new.checksum_ok    = ok;
        res_new.arm_value      = arm_reg;
        res_new.throttle_value = thr_reg;

        if (accept)
        begin
            if (byte_in.frame_start)
            begin
                in_frame_next = 1'b1;
                if (byte_in.data_byte == ctrl_hdr_reg)
                    kind_next = KIND_CONTROL;
                else if (byte_in.data_byte == set_hdr_reg)
                    kind_next = KIND_SETTINGS;
                else if (byte_in.data_byte == mag_hdr_reg)
                    kind_next = KIND_MAG_CAL;
                else if (byte_in.data_byte == acc_hdr_reg)
                    kind_next = KIND_ACC_CAL;
                else
                    in_frame_next = 1'b0;
                sum_lo_next = '0;
                sum_hi_next = '0;
                chk1_next   = '0;
                pos_next    = 8'd1;
            end
            else if (in_frame_reg)
            begin
                pos_next = pos_reg + 8'd1;
                if (pos_reg <= payload_len)
                begin
                    sum_lo_next = sum_lo_add;
                    sum_hi_next = sum_hi_reg + sum_lo_add;
                    // payload positions 1 to 5 of a control frame
                    if (kind_reg == KIND_CONTROL && pos_reg >= 8'd1
                        && pos_reg <= CTRL_PAYLOAD_LEN)
                        ctrl_we = 1'b1;
                end
                else if ({1'b0, pos_reg} == {1'b0, payload_len} + 9'd1)
                begin
                    chk1_next = byte_in.data_byte;
                end
                else
                begin
                    has_result    = 1'b1;
                    in_frame_next = 1'b0;
                    if (kind_reg == KIND_CONTROL && ok)
                    begin
                        res_new.range_value = {ctrl_bytes[0], ctrl_bytes[1]};
                        res_new.arm_rise = (ctrl_bytes[2] == 8'd1) && (arm_reg == 8'd0);
                        res_new.arm_fall = (ctrl_bytes[2] == 8'd0) && (arm_reg == 8'd1);
                        arm_next = ctrl_bytes[2];
                        if (ctrl_bytes[2] == 8'd1)
                            thr_next = {ctrl_bytes[3], ctrl_bytes[4]};
                        else
                            thr_next = IDLE_THROTTLE;
                        res_new.arm_value      = arm_next;
                        res_new.throttle_value = thr_next;
                    end
                end
            end
        end
    end

    // output register with skid stage
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || result_out.ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res_new;
                out_valid_next = has_result;
            end
        end
        else if (has_result)
        begin
            skid_next       = res_new;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            in_frame_reg   <= 1'b0;
            kind_reg       <= KIND_CONTROL;
            sum_lo_reg     <= '0;
            sum_hi_reg     <= '0;
            chk1_reg       <= '0;
            arm_reg        <= '0;
            thr_reg        <= IDLE_THROTTLE;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            in_frame_reg   <= in_frame_next;
            kind_reg       <= kind_next;
            sum_lo_reg     <= sum_lo_next;
            sum_hi_reg     <= sum_hi_next;
            chk1_reg       <= chk1_next;
            arm_reg        <= arm_next;
            thr_reg        <= thr_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (ctrl_we)
            ctrl_bytes[ctrl_idx] <= byte_in.data_byte;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.frame_kind     = out_reg.frame_kind;
    assign result_out.checksum_ok    = out_reg.checksum_ok;
    assign result_out.range_value    = out_reg.range_value;
    assign result_out.arm_value      = out_reg.arm_value;
    assign result_out.throttle_value = out_reg.throttle_value;
    assign result_out.arm_rise       = out_reg.arm_rise;
    assign result_out.arm_fall       = out_reg.arm_fall;

endmodule
